>>> hw/rtl/ukrlat_pkg.sv
package ukrlat_pkg;

	localparam int MaxPoints = 4;
	localparam logic [15:0] Caron = 16'h030C;

	typedef enum logic [2:0] {
		K_NONE,
		K_CONS,
		K_VOW,
		K_IOT,
		K_SOFT,
		K_APOS
	} kind_t;

	// m0 and m1 are the lower-case latin mapping, 0 where absent
	typedef struct packed {
		kind_t       kind;
		logic        upper;
		logic [15:0] m0;
		logic [15:0] m1;
	} letter_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] letter;
	} ukrlat_held_t;

	typedef struct packed {
		logic [MaxPoints-1:0][15:0] codes;
		logic [2:0]                 cnt;
	} ukrlat_res_t;

	function automatic logic [15:0] to_upper(input logic [15:0] c);
		logic [15:0] r;
		r = c;
		if (c >= 16'h0061 && c <= 16'h007A) begin
			r = 16'(c - 16'h0020);
		end else if (c == 16'h015B) begin
			r = 16'h015A;
		end else if (c == 16'h0107) begin
			r = 16'h0106;
		end else if (c == 16'h0292) begin
			r = 16'h01B7;
		end
		return r;
	endfunction

	function automatic letter_t letter_info(input logic [15:0] u);
		letter_t     e;
		logic [15:0] l;
		l = u;
		e.upper = 1'b0;
		if (u >= 16'h0410 && u <= 16'h042F) begin
			l = 16'(u + 16'h0020);
			e.upper = 1'b1;
		end else if (u >= 16'h0400 && u <= 16'h040F) begin
			l = 16'(u + 16'h0050);
			e.upper = 1'b1;
		end else if (u == 16'h0490) begin
			l = 16'h0491;
			e.upper = 1'b1;
		end
		e.kind = K_CONS;
		e.m1 = 16'h0000;
		unique case (l)
			16'h0439: e.m0 = 16'h006A;
			16'h0446: e.m0 = 16'h0063;
			16'h043A: e.m0 = 16'h006B;
			16'h043D: e.m0 = 16'h006E;
			16'h0433: e.m0 = 16'h0068;
			16'h0448: e.m0 = 16'h015B;
			16'h0449: begin
				e.m0 = 16'h015B;
				e.m1 = 16'h0107;
			end
			16'h0437: e.m0 = 16'h007A;
			16'h0445: e.m0 = 16'h0078;
			16'h0444: e.m0 = 16'h0066;
			16'h0432: e.m0 = 16'h0076;
			16'h043F: e.m0 = 16'h0070;
			16'h0440: e.m0 = 16'h0072;
			16'h043B: e.m0 = 16'h006C;
			16'h0434: e.m0 = 16'h0064;
			16'h0436: e.m0 = 16'h0292;
			16'h0447: e.m0 = 16'h0107;
			16'h0441: e.m0 = 16'h0073;
			16'h043C: e.m0 = 16'h006D;
			16'h0442: e.m0 = 16'h0074;
			16'h0431: e.m0 = 16'h0062;
			16'h0491: e.m0 = 16'h0067;
			16'h044C: begin
				e.kind = K_SOFT;
				e.m0 = 16'h0000;
			end
			16'h0443: begin
				e.kind = K_VOW;
				e.m0 = 16'h0075;
			end
			16'h0435: begin
				e.kind = K_VOW;
				e.m0 = 16'h0065;
			end
			16'h0456: begin
				e.kind = K_VOW;
				e.m0 = 16'h0069;
			end
			16'h0430: begin
				e.kind = K_VOW;
				e.m0 = 16'h0061;
			end
			16'h043E: begin
				e.kind = K_VOW;
				e.m0 = 16'h006F;
			end
			16'h0438: begin
				e.kind = K_VOW;
				e.m0 = 16'h0079;
			end
			16'h0457: begin
				e.kind = K_IOT;
				e.m0 = 16'h006A;
				e.m1 = 16'h0069;
			end
			16'h0454: begin
				e.kind = K_IOT;
				e.m0 = 16'h006A;
				e.m1 = 16'h0065;
			end
			16'h044F: begin
				e.kind = K_IOT;
				e.m0 = 16'h006A;
				e.m1 = 16'h0061;
			end
			16'h044E: begin
				e.kind = K_IOT;
				e.m0 = 16'h006A;
				e.m1 = 16'h0075;
			end
			16'h0027: begin
				e.kind = K_APOS;
				e.m0 = 16'h0000;
			end
			default: begin
				e.kind = K_NONE;
				e.m0 = 16'h0000;
			end
		endcase
		return e;
	endfunction

endpackage

>>> hw/rtl/ukrlat_map.sv
module ukrlat_map
	import ukrlat_pkg::*;
(
	input  logic [15:0]  code_unit,
	input  logic         end_of_text,
	input  ukrlat_held_t held,
	output ukrlat_held_t held_nx,
	output ukrlat_res_t  res
);

	letter_t     ui;
	letter_t     hi;
	logic        is_letter;
	logic        pair;
	logic        hold_new;
	logic        emit_new;
	logic [2:0]  n;

	always_comb begin
		ui = letter_info(code_unit);
		hi = letter_info(held.letter);
		is_letter = (ui.kind != K_NONE);
		pair = held.valid && is_letter && (ui.kind == K_APOS || ui.kind == K_SOFT ||
			(ui.kind == K_IOT && (hi.kind == K_CONS || hi.kind == K_SOFT)));
		hold_new = is_letter && !pair;
		emit_new = hold_new && end_of_text;

		held_nx.valid = hold_new && !end_of_text;
		held_nx.letter = hold_new ? code_unit : held.letter;

		// append points in output order, never more than four
		res.codes = '0;
		n = 3'd0;
		if (held.valid && hi.m0 != 16'h0000) begin
			res.codes[n[1:0]] = hi.upper ? to_upper(hi.m0) : hi.m0;
			n = n + 3'd1;
		end
		if (held.valid && hi.m1 != 16'h0000) begin
			res.codes[n[1:0]] = hi.m1;
			n = n + 3'd1;
		end
		if (pair && ui.kind != K_APOS) begin
			res.codes[n[1:0]] = Caron;
			n = n + 3'd1;
		end
		if (pair && ui.kind == K_IOT) begin
			res.codes[n[1:0]] = ui.upper ? to_upper(ui.m1) : ui.m1;
			n = n + 3'd1;
		end
		if (emit_new && ui.m0 != 16'h0000) begin
			res.codes[n[1:0]] = ui.upper ? to_upper(ui.m0) : ui.m0;
			n = n + 3'd1;
		end
		if (emit_new && ui.m1 != 16'h0000) begin
			res.codes[n[1:0]] = ui.m1;
			n = n + 3'd1;
		end
		if (!is_letter) begin
			res.codes[n[1:0]] = code_unit;
			n = n + 3'd1;
		end
		res.cnt = n;
	end

endmodule

>>> hw/rtl/ukrlat_out.sv
module ukrlat_out
	import ukrlat_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  ukrlat_res_t res,
	output logic        free,
	output logic        point_valid,
	input  logic        point_stall,
	output logic [15:0] code_point,
	output logic        last
);

	logic [MaxPoints-1:0][15:0] codes_s2;
	logic [2:0]                 cnt_s2;
	logic                       valid_s2;
	logic [1:0]                 idx_q;

	assign point_valid = valid_s2;
	assign code_point = codes_s2[idx_q];
	assign last = (3'({1'b0, idx_q}) + 3'd1 == cnt_s2);
	// slot frees when empty or its final beat leaves this cycle
	assign free = !valid_s2 || (!point_stall && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q <= 2'd0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_q <= 2'd0;
		end else if (valid_s2 && !point_stall) begin
			if (last) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			codes_s2 <= res.codes;
			cnt_s2 <= res.cnt;
		end
	end

endmodule

>>> hw/rtl/cyrillic_latin_transliterator.sv
// channel   | beat fields                 | handshake
// ----------+-----------------------------+-------------------------
// unit in   | code_unit, end_of_text      | unit_valid / unit_stall
// point out | code_point, last            | point_valid / point_stall
//
// a unit enters an input register, is mapped combinationally and lands in the result register
// the result register sends an item's points, 1 to 4, one point per cycle while point_stall is low
// units that give no point leave the input register without waiting on the result side
// reset clears the held letter and all valid flags; no clearing pass
// point_stall holds the result register; unit_stall rises only when the input register is full
module cyrillic_latin_transliterator
	import ukrlat_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        unit_valid,
	output logic        unit_stall,
	input  logic [15:0] code_unit,
	input  logic        end_of_text,
	output logic        point_valid,
	input  logic        point_stall,
	output logic [15:0] code_point,
	output logic        last
);

	logic         valid_s1;
	logic [15:0]  code_unit_s1;
	logic         eot_s1;
	ukrlat_held_t held_q;
	ukrlat_held_t held_nx;
	ukrlat_res_t  res;
	logic         free;
	logic         adv;
	logic         load;

	ukrlat_map u_map (
		.code_unit   (code_unit_s1),
		.end_of_text (eot_s1),
		.held        (held_q),
		.held_nx     (held_nx),
		.res         (res)
	);

	assign adv = valid_s1 && (res.cnt == 3'd0 || free);
	assign load = adv && (res.cnt != 3'd0);
	assign unit_stall = valid_s1 && !adv;

	ukrlat_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.res         (res),
		.free        (free),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.code_point  (code_point),
		.last        (last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			held_q <= '0;
		end else begin
			if (unit_valid && !unit_stall) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				held_q <= held_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (unit_valid && !unit_stall) begin
			code_unit_s1 <= code_unit;
			eot_s1 <= end_of_text;
		end
	end

`ifndef SYNTHESIS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("result register loaded while occupied");
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> point_valid && code_point == $past(res.codes[0]))
		else $error("loaded result not presented");
	a_eot_flush: assert property (@(posedge clk) disable iff (!arst_n)
		adv && eot_s1 |=> !held_q.valid)
		else $error("held letter survives end of text");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		unit_stall |-> valid_s1 && res.cnt != 3'd0 && point_valid)
		else $error("input stalled without cause");
`endif

endmodule

>>> tb/sv/cyrillic_latin_transliterator_test.sv
module cyrillic_latin_transliterator_test;
	import ukrlat_pkg::*;

	localparam int IdlePct = 29;
	localparam int HangLimit = 2000;
	localparam int RandomUnits = 350;

	typedef struct packed {
		kind_t       kind;
		logic        up;
		logic [15:0] first;
		logic [15:0] second;
		logic [15:0] vowel;
	} glyph_t;

	typedef struct packed {
		logic [15:0] code;
		logic        last;
	} point_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        unit_valid = 1'b0;
	logic        unit_stall;
	logic [15:0] code_unit = 16'h0000;
	logic        end_of_text = 1'b0;
	logic        point_valid;
	logic        point_stall = 1'b0;
	logic [15:0] code_point;
	logic        last;

	logic        calm = 1'b0;
	logic [15:0] held_code = 16'h0000;
	logic        held_on = 1'b0;
	logic [15:0] latin_run[$];
	point_t      points_due[$];
	int unsigned failures = 0;
	int unsigned units_sent = 0;
	int unsigned points_seen = 0;
	int unsigned quiet_cycles = 0;

	logic [15:0] alphabet[34] = '{
		16'h0439, 16'h0446, 16'h043A, 16'h043D, 16'h0433, 16'h0448, 16'h0449,
		16'h0437, 16'h0445, 16'h0444, 16'h0432, 16'h043F, 16'h0440, 16'h043B,
		16'h0434, 16'h0436, 16'h0447, 16'h0441, 16'h043C, 16'h0442, 16'h044C,
		16'h0431, 16'h0491, 16'h0443, 16'h0435, 16'h0456, 16'h0430, 16'h043E,
		16'h0438, 16'h0457, 16'h0454, 16'h044F, 16'h044E, 16'h0027
	};

	cyrillic_latin_transliterator u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.unit_valid  (unit_valid),
		.unit_stall  (unit_stall),
		.code_unit   (code_unit),
		.end_of_text (end_of_text),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.code_point  (code_point),
		.last        (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic glyph_t read_glyph(input logic [15:0] u);
		glyph_t      g;
		logic [15:0] lc;
		g = '0;
		lc = u;
		if (u >= 16'h0410 && u <= 16'h042F) begin
			lc = u + 16'h0020;
			g.up = 1'b1;
		end else if (u >= 16'h0400 && u <= 16'h040F) begin
			lc = u + 16'h0050;
			g.up = 1'b1;
		end else if (u == 16'h0490) begin
			lc = 16'h0491;
			g.up = 1'b1;
		end
		g.kind = K_CONS;
		case (lc)
			16'h0439: g.first = "j";
			16'h0446: g.first = "c";
			16'h043A: g.first = "k";
			16'h043D: g.first = "n";
			16'h0433: g.first = "h";
			16'h0448: g.first = 16'h015B;
			16'h0449: begin
				g.first = 16'h015B;
				g.second = 16'h0107;
			end
			16'h0437: g.first = "z";
			16'h0445: g.first = "x";
			16'h0444: g.first = "f";
			16'h0432: g.first = "v";
			16'h043F: g.first = "p";
			16'h0440: g.first = "r";
			16'h043B: g.first = "l";
			16'h0434: g.first = "d";
			16'h0436: g.first = 16'h0292;
			16'h0447: g.first = 16'h0107;
			16'h0441: g.first = "s";
			16'h043C: g.first = "m";
			16'h0442: g.first = "t";
			16'h0431: g.first = "b";
			16'h0491: g.first = "g";
			16'h044C: g.kind = K_SOFT;
			16'h0443, 16'h0435, 16'h0456, 16'h0430, 16'h043E, 16'h0438: begin
				g.kind = K_VOW;
				case (lc)
					16'h0443: g.first = "u";
					16'h0435: g.first = "e";
					16'h0456: g.first = "i";
					16'h0430: g.first = "a";
					16'h043E: g.first = "o";
					default: g.first = "y";
				endcase
			end
			16'h0457, 16'h0454, 16'h044F, 16'h044E: begin
				g.kind = K_IOT;
				g.first = "j";
				case (lc)
					16'h0457: g.vowel = "i";
					16'h0454: g.vowel = "e";
					16'h044F: g.vowel = "a";
					default: g.vowel = "u";
				endcase
				g.second = g.vowel;
			end
			16'h0027: g.kind = K_APOS;
			default: g.kind = K_NONE;
		endcase
		return g;
	endfunction

	function automatic logic [15:0] capital_of(input logic [15:0] c);
		if (c >= "a" && c <= "z")
			return c - 16'h0020;
		case (c)
			16'h015B: return 16'h015A;
			16'h0107: return 16'h0106;
			16'h0292: return 16'h01B7;
			default: return c;
		endcase
	endfunction

	// only the first latin letter takes the capital
	function automatic void spell(input glyph_t g);
		if (g.first != 16'h0000) begin
			latin_run.push_back(g.up ? capital_of(g.first) : g.first);
			if (g.second != 16'h0000)
				latin_run.push_back(g.second);
		end
	endfunction

	function automatic void release_held();
		if (held_on) begin
			spell(read_glyph(held_code));
			held_on = 1'b0;
		end
	endfunction

	function automatic void transliterate(input logic [15:0] cu, input logic eot);
		glyph_t g;
		glyph_t h;
		point_t p;
		latin_run.delete();
		g = read_glyph(cu);
		if (g.kind == K_NONE) begin
			release_held();
			latin_run.push_back(cu);
		end else if (!held_on) begin
			held_code = cu;
			held_on = 1'b1;
		end else begin
			h = read_glyph(held_code);
			spell(h);
			if (g.kind == K_APOS || g.kind == K_SOFT ||
			    (g.kind == K_IOT && (h.kind == K_CONS || h.kind == K_SOFT))) begin
				if (g.kind != K_APOS)
					latin_run.push_back(Caron);
				if (g.kind == K_IOT)
					latin_run.push_back(g.up ? capital_of(g.vowel) : g.vowel);
				held_on = 1'b0;
			end else begin
				held_code = cu;
			end
		end
		if (eot)
			release_held();
		while (latin_run.size() > MaxPoints)
			void'(latin_run.pop_back());
		foreach (latin_run[i]) begin
			p.code = latin_run[i];
			p.last = (i == latin_run.size() - 1);
			points_due.push_back(p);
		end
	endfunction

	task automatic send_unit(input logic [15:0] cu, input logic eot);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < IdlePct) begin
			unit_valid <= 1'b0;
			@(negedge clk);
		end
		unit_valid <= 1'b1;
		code_unit <= cu;
		end_of_text <= eot;
		@(posedge clk);
		while (unit_stall)
			@(posedge clk);
		transliterate(cu, eot);
		units_sent++;
	endtask

	always @(negedge clk)
		point_stall <= !calm && ($urandom_range(0, 99) < IdlePct);

	always @(posedge clk) begin
		point_t want;
		if (arst_n && point_valid && !point_stall) begin
			points_seen++;
			if (points_due.size() == 0) begin
				$error("code point %h with nothing expected", code_point);
				failures++;
			end else begin
				want = points_due.pop_front();
				if (code_point !== want.code) begin
					$error("code_point: expected %h, actual %h", want.code, code_point);
					failures++;
				end
				if (last !== want.last) begin
					$error("last: expected %b, actual %b", want.last, last);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((unit_valid && !unit_stall) || (point_valid && !point_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= HangLimit) begin
			$display("hang: %0d cycles without a beat", quiet_cycles);
			$display("status: fail");
			$finish;
		end
	end

	task automatic test_passthrough();
		send_unit(16'h0000, 1'b0);
		send_unit(16'hFFFF, 1'b0);
		send_unit(16'hD83D, 1'b0);
		send_unit(16'h8000, 1'b1);
	endtask

	task automatic test_letter_pairs();
		send_unit(16'h0449, 1'b0);  // shch then capital ya: four points
		send_unit(16'h042F, 1'b0);
		send_unit(16'h044C, 1'b1);  // soft sign alone
		send_unit(16'h0027, 1'b0);
		send_unit(16'h0454, 1'b0);  // apostrophe is no consonant
		send_unit(16'h0020, 1'b0);
		send_unit(16'h0416, 1'b0);
		send_unit(16'h0027, 1'b0);
		send_unit(16'h044C, 1'b0);  // soft-led pair, caron with no letter
		send_unit(16'h044E, 1'b0);
		send_unit(16'h0404, 1'b0);
		send_unit(16'h0490, 1'b0);
		send_unit(16'h0430, 1'b1);
		send_unit(16'h0406, 1'b0);
		send_unit(16'h0407, 1'b0);
		send_unit(16'h044C, 1'b0);
		send_unit(16'h0027, 1'b0);
		send_unit(16'h0027, 1'b1);
		send_unit(16'h0429, 1'b0);
		send_unit(16'h0457, 1'b1);
	endtask

	function automatic logic [15:0] pick_letter();
		logic [15:0] c;
		c = alphabet[$urandom_range(0, 33)];
		if (c != 16'h0027 && $urandom_range(0, 2) == 0) begin
			if (c >= 16'h0430 && c <= 16'h044F)
				c = c - 16'h0020;
			else if (c == 16'h0491)
				c = 16'h0490;
			else
				c = c - 16'h0050;
		end
		return c;
	endfunction

	task automatic test_random_text();
		int          sent;
		int          len;
		logic [15:0] cu;
		logic        eot;
		sent = 0;
		while (sent < RandomUnits) begin
			calm = (sent >= 150 && sent < 230);
			if ($urandom_range(0, 99) < 12) begin
				if ($urandom_range(0, 1) == 0)
					cu = 16'($urandom);
				else
					cu = 16'h0400 + 16'($urandom_range(0, 255));
				send_unit(cu, $urandom_range(0, 7) == 0);
				sent++;
			end else begin
				len = $urandom_range(1, 6);
				eot = 1'b0;
				for (int i = 0; i < len; i++) begin
					eot = (i == len - 1) && ($urandom_range(0, 3) == 0);
					send_unit(pick_letter(), eot);
					sent++;
				end
				// some words run into the next one with no separator
				if (!eot && $urandom_range(0, 3) != 0) begin
					case ($urandom_range(0, 4))
						0: cu = 16'h0020;
						1: cu = 16'h002C;
						2: cu = 16'h002E;
						3: cu = 16'h000A;
						default: cu = 16'h0021;
					endcase
					send_unit(cu, $urandom_range(0, 5) == 0);
					sent++;
				end
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_passthrough();
		test_letter_pairs();
		test_random_text();
		@(negedge clk);
		unit_valid <= 1'b0;
		while (points_due.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		$display("sent %0d code units, checked %0d latin code points", units_sent, points_seen);
		$display("mismatches and strays: %0d", failures);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
